[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define RMBD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define RMBD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rmbd_pkg.sv]
// Types and constants shared by the multi-bulk request deframer files.
`default_nettype none

package rmbd_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_FRAMING      = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD      = 3'd1;
  localparam logic [2:0] KIND_EMPTY_ARG    = 3'd2;
  localparam logic [2:0] KIND_EMPTY_CMD    = 3'd3;
  localparam logic [2:0] KIND_ERROR        = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_COUNT_LONG    = 3'd1;
  localparam logic [2:0] ERR_BAD_COUNT     = 3'd2;
  localparam logic [2:0] ERR_NO_DOLLAR     = 3'd3;
  localparam logic [2:0] ERR_BAD_LENGTH    = 3'd4;
  localparam logic [2:0] ERR_LENGTH_LONG   = 3'd5;
  localparam logic [2:0] ERR_INLINE        = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_LINE      = 2'd0;
  localparam logic [1:0] REG_MAX_COUNT     = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

  localparam logic [16:0] MAX_LINE_RESET   = 17'd65536;
  localparam logic [20:0] MAX_COUNT_RESET  = 21'd1048576;
  localparam logic [29:0] MAX_LENGTH_RESET = 30'd536870912;

  // Protocol characters.
  localparam logic [7:0] CHAR_STAR         = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR       = 8'h24;
  localparam logic [7:0] CHAR_CR           = 8'h0D;
  localparam logic [7:0] CHAR_MINUS        = 8'h2D;
  localparam logic [7:0] CHAR_ZERO         = 8'h30;
  localparam logic [7:0] CHAR_NINE         = 8'h39;

  // Largest value the decimal accumulator holds before flagging overflow.
  localparam logic [30:0] NUMBER_MAX       = 31'h7FFF_FFFF;

  typedef struct packed {
    logic bad;
    logic zero;
    logic digits;
    logic over;
    logic sign;
  } num_flags_t;

endpackage

`default_nettype wire

[hw/rtl/rmbd_number.sv]
// Decimal accumulator step: folds one character into a count or length value.
`default_nettype none

module rmbd_number (
  input  logic [30:0]           value,
  input  rmbd_pkg::num_flags_t  flags,
  input  logic                  line_empty,
  input  logic [7:0]            data,
  output logic [30:0]           value_next,
  output rmbd_pkg::num_flags_t  flags_next
);
  import rmbd_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [34:0] scaled;

  assign is_digit = (data >= CHAR_ZERO) && (data <= CHAR_NINE);
  assign digit    = 4'(data - CHAR_ZERO);
  assign scaled   = ({4'd0, value} << 3) + ({4'd0, value} << 1) + {31'd0, digit};

  always_comb begin
    value_next = value;
    flags_next = flags;
    if (!flags.bad) begin
      if (is_digit) begin
        if (flags.zero) begin
          flags_next.bad = 1'b1;
        end else if (!flags.digits) begin
          if (digit == 4'd0) begin
            // A lone zero is fine, a negative zero is not.
            if (flags.sign) begin
              flags_next.bad = 1'b1;
            end else begin
              flags_next.zero   = 1'b1;
              flags_next.digits = 1'b1;
            end
          end else begin
            flags_next.digits = 1'b1;
            value_next        = {27'd0, digit};
          end
        end else if (!flags.over) begin
          if (scaled > {4'd0, NUMBER_MAX}) begin
            flags_next.over = 1'b1;
          end else begin
            value_next = scaled[30:0];
          end
        end
      end else if ((data == CHAR_MINUS) && line_empty) begin
        flags_next.sign = 1'b1;
      end else begin
        flags_next.bad = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/resp_multibulk_request_deframer.sv]
// Top level of the multi-bulk request deframer: parser state and result register.
`default_nettype none

// The result word of an accepted word is held in the result register.
// Throughput: one word per cycle; the parser state and the result register update in
// the same cycle, so only a stalled result word holds the input back.
// Reset (rst, synchronous, active high) clears the parser state, the closed flag and
// the result register, and loads the reset values of the three limit registers.
module resp_multibulk_request_deframer #(
  parameter int COUNT_BITS  = 21,
  parameter int LENGTH_BITS = 30
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data,
  // Request byte stream.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // Result stream.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        argument_last,
  output logic        command_last,
  output logic [19:0] argument_number,
  output logic [2:0]  error_code
);
  import rmbd_pkg::*;

  // Parser phases. Codes that are not listed behave as awaiting a request start.
  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_COUNT       = 4'd1,
    PH_COUNT_SKIP  = 4'd2,
    PH_DOLLAR      = 4'd3,
    PH_LENGTH      = 4'd4,
    PH_LENGTH_SKIP = 4'd5,
    PH_PAYLOAD     = 4'd6,
    PH_TRAIL1      = 4'd7,
    PH_TRAIL2      = 4'd8
  } phase_t;

  // Largest values that the argument and byte counters can hold.
  localparam logic [40:0] COUNT_FIELD_MAX  = (41'd1 << COUNT_BITS) - 41'd1;
  localparam logic [40:0] LENGTH_FIELD_MAX = (41'd1 << LENGTH_BITS) - 41'd1;
  localparam logic [COUNT_BITS-1:0]  COUNT_ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic [COUNT_BITS-1:0]  COUNT_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LENGTH_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [LENGTH_BITS-1:0] LENGTH_ZERO = '0;

  // Limit registers.
  logic [16:0] max_line_length;
  logic [20:0] max_argument_count;
  logic [29:0] max_argument_length;

  // Parser state.
  phase_t                 phase, phase_next;
  logic [COUNT_BITS-1:0]  arguments_left, arguments_left_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [30:0]            number_value, number_value_next;
  num_flags_t             number_flags, number_flags_next;
  logic [16:0]            line_length, line_length_next;
  logic [19:0]            argument_index, argument_index_next;
  logic                   closed, closed_next;

  // Result fields computed for the word being accepted.
  logic [2:0]  res_kind;
  logic [7:0]  res_payload;
  logic        res_arg_last;
  logic        res_cmd_last;
  logic [19:0] res_arg_num;
  logic [2:0]  res_error;

  // Accumulator step for count and length characters.
  logic [30:0] take_value;
  num_flags_t  take_flags;

  logic        accept;
  logic [40:0] value_ext;
  logic        number_ok;
  logic        last_argument;
  logic [LENGTH_BITS-1:0] bytes_after;

  rmbd_number u_number (
    .value      (number_value),
    .flags      (number_flags),
    .line_empty (line_length == 17'd0),
    .data       (data_byte),
    .value_next (take_value),
    .flags_next (take_flags)
  );

  // The result register parts the two sides: a new word is taken whenever the
  // result register is empty or its word leaves in this same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign value_ext     = {10'd0, number_value};
  assign number_ok     = number_flags.digits && !number_flags.bad;
  assign last_argument = (arguments_left <= COUNT_ONE);
  assign bytes_after   = (bytes_left != LENGTH_ZERO) ? (bytes_left - LENGTH_ONE) : LENGTH_ZERO;

  // One parser step for the incoming byte.
  always_comb begin
    phase_next          = phase;
    arguments_left_next = arguments_left;
    bytes_left_next     = bytes_left;
    number_value_next   = number_value;
    number_flags_next   = number_flags;
    line_length_next    = line_length;
    argument_index_next = argument_index;
    closed_next         = closed;
    res_kind            = KIND_FRAMING;
    res_payload         = 8'd0;
    res_arg_last        = 1'b0;
    res_cmd_last        = 1'b0;
    res_arg_num         = 20'd0;
    res_error           = ERR_NONE;

    if (!closed) begin
      case (phase)
        PH_COUNT, PH_LENGTH: begin
          if (data_byte == CHAR_CR) begin
            phase_next = (phase == PH_COUNT) ? PH_COUNT_SKIP : PH_LENGTH_SKIP;
          end else if (line_length >= max_line_length) begin
            res_kind  = KIND_ERROR;
            res_error = (phase == PH_COUNT) ? ERR_COUNT_LONG : ERR_LENGTH_LONG;
          end else begin
            number_value_next = take_value;
            number_flags_next = take_flags;
            line_length_next  = line_length + 17'd1;
          end
        end
        PH_COUNT_SKIP: begin
          // The byte after CR carries the verdict on the count.
          if (!number_ok) begin
            res_kind  = KIND_ERROR;
            res_error = ERR_BAD_COUNT;
          end else if (number_flags.sign || (number_value == 31'd0)) begin
            res_kind     = KIND_EMPTY_CMD;
            res_cmd_last = 1'b1;
            phase_next   = PH_START;
          end else if (number_flags.over ||
                       (value_ext > {20'd0, max_argument_count}) ||
                       (value_ext > COUNT_FIELD_MAX)) begin
            res_kind  = KIND_ERROR;
            res_error = ERR_BAD_COUNT;
          end else begin
            arguments_left_next = value_ext[COUNT_BITS-1:0];
            argument_index_next = 20'd0;
            phase_next          = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (data_byte == CHAR_DOLLAR) begin
            number_value_next = 31'd0;
            number_flags_next = '0;
            line_length_next  = 17'd0;
            phase_next        = PH_LENGTH;
          end else begin
            res_kind  = KIND_ERROR;
            res_error = ERR_NO_DOLLAR;
          end
        end
        PH_LENGTH_SKIP: begin
          if (!number_ok || number_flags.sign || number_flags.over ||
              (value_ext > {11'd0, max_argument_length}) ||
              (value_ext > LENGTH_FIELD_MAX)) begin
            res_kind  = KIND_ERROR;
            res_error = ERR_BAD_LENGTH;
          end else if (number_value == 31'd0) begin
            res_kind     = KIND_EMPTY_ARG;
            res_arg_last = 1'b1;
            res_cmd_last = last_argument;
            res_arg_num  = argument_index;
            phase_next   = PH_TRAIL1;
          end else begin
            bytes_left_next = value_ext[LENGTH_BITS-1:0];
            phase_next      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_kind        = KIND_PAYLOAD;
          res_payload     = data_byte;
          res_arg_num     = argument_index;
          bytes_left_next = bytes_after;
          if (bytes_after == LENGTH_ZERO) begin
            res_arg_last = 1'b1;
            res_cmd_last = last_argument;
            phase_next   = PH_TRAIL1;
          end
        end
        PH_TRAIL1: begin
          phase_next = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          // Second trailing byte closes the argument; move on or end the command.
          if (arguments_left <= COUNT_ONE) begin
            arguments_left_next = COUNT_ZERO;
            argument_index_next = 20'd0;
            phase_next          = PH_START;
          end else begin
            arguments_left_next = arguments_left - COUNT_ONE;
            argument_index_next = argument_index + 20'd1;
            phase_next          = PH_DOLLAR;
          end
        end
        default: begin
          if (data_byte == CHAR_STAR) begin
            number_value_next = 31'd0;
            number_flags_next = '0;
            line_length_next  = 17'd0;
            phase_next        = PH_COUNT;
          end else begin
            res_kind  = KIND_ERROR;
            res_error = ERR_INLINE;
          end
        end
      endcase

      // Any fault closes the block until the next reset.
      if (res_kind == KIND_ERROR) begin
        closed_next = 1'b1;
        phase_next  = PH_START;
      end
    end
  end

  // Limit registers: write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length     <= MAX_LINE_RESET;
      max_argument_count  <= MAX_COUNT_RESET;
      max_argument_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_LINE:   max_line_length     <= cfg_data[16:0];
        REG_MAX_COUNT:  max_argument_count  <= cfg_data[20:0];
        REG_MAX_LENGTH: max_argument_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state and result register advance together on each accepted word; the
  // result valid drops once its word has left and nothing new was taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      arguments_left  <= COUNT_ZERO;
      bytes_left      <= LENGTH_ZERO;
      number_value    <= 31'd0;
      number_flags    <= '0;
      line_length     <= 17'd0;
      argument_index  <= 20'd0;
      closed          <= 1'b0;
      out_valid       <= 1'b0;
      kind            <= KIND_FRAMING;
      payload_byte    <= 8'd0;
      argument_last   <= 1'b0;
      command_last    <= 1'b0;
      argument_number <= 20'd0;
      error_code      <= ERR_NONE;
    end else if (accept) begin
      phase           <= phase_next;
      arguments_left  <= arguments_left_next;
      bytes_left      <= bytes_left_next;
      number_value    <= number_value_next;
      number_flags    <= number_flags_next;
      line_length     <= line_length_next;
      argument_index  <= argument_index_next;
      closed          <= closed_next;
      out_valid       <= 1'b1;
      kind            <= res_kind;
      payload_byte    <= res_payload;
      argument_last   <= res_arg_last;
      command_last    <= res_cmd_last;
      argument_number <= res_arg_num;
      error_code      <= res_error;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rmbd_checker.sv]
// Port-level assertion checker for the deframer, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module rmbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [2:0] error_code
);
  import rmbd_pkg::*;

  // Set once an error word has been delivered downstream.
  logic seen_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_error <= 1'b0;
    end else if (out_valid && !out_stall && (kind == KIND_ERROR)) begin
      seen_error <= 1'b1;
    end
  end

  `RMBD_ASSERT(a_closed_quiet, clk, rst, (seen_error && out_valid) |-> ((kind == KIND_FRAMING) && (error_code == ERR_NONE)), "word after an error is not quiet framing")
  `RMBD_ASSERT_ALWAYS(a_stall_only_when_full, clk, in_stall |-> (out_valid && out_stall), "input stalled while the result register can take a word")
  `RMBD_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> !out_valid, "result valid set right after reset")
  `RMBD_ASSERT(a_accept_gives_result, clk, rst, (in_valid && !in_stall) |=> out_valid, "accepted word gave no result")
  `RMBD_ASSERT(a_held_result, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(error_code)), "stalled result word changed")

endmodule

bind resp_multibulk_request_deframer rmbd_checker u_rmbd_checker (.*);

`default_nettype wire

[verif/tb_resp_multibulk_request_deframer.sv]
// Self-checking testbench for the multi-bulk request deframer: directed and random byte streams.
`default_nettype none

module tb_resp_multibulk_request_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import rmbd_pkg::*;

  // The bench stops if this many cycles pass with no word moving on either side.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Least number of random bytes generated per configuration phase before the phase is sent.
  localparam int unsigned PHASE_BYTES = 70;
  localparam int unsigned PHASE_COUNT = 6;
  // Field limits of the default build of the block.
  localparam longint unsigned COUNT_FIELD_MAX  = (64'd1 << 21) - 64'd1;
  localparam longint unsigned LENGTH_FIELD_MAX = (64'd1 << 30) - 64'd1;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    PH_START,
    PH_COUNT,
    PH_COUNT_SKIP,
    PH_DOLLAR,
    PH_LENGTH,
    PH_LENGTH_SKIP,
    PH_PAYLOAD,
    PH_TRAIL1,
    PH_TRAIL2
  } parse_phase_e;

  // One result word, in the order of the output ports.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic        alast;
    logic        clast;
    logic [19:0] anum;
    logic [2:0]  err;
  } result_t;

  // One request byte with an optional typed-in expectation.
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } stim_t;

  // Row of the directed table: a byte and, for typed rows, the kind and command mark
  // that it must give (every other field of a typed row is expected to be zero).
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [2:0] kind;
    logic       clast;
  } row_t;

  localparam logic TYPED = 1'b1;
  localparam logic FREE  = 1'b0;

  // Directed part. The first three requests are read off by hand: an empty command from a
  // zero count, an empty command from a negative count, and the framing of a two-argument
  // count and of its first length line. The rest (the empty argument, then the extreme
  // payload bytes 00 and FF ending the command) is left to the predictor.
  localparam row_t DIRECTED_ROWS [27] = '{
    {CHAR_STAR,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_ZERO,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_CR,            TYPED, KIND_FRAMING,   1'b0},
    {8'h0A,              TYPED, KIND_EMPTY_CMD, 1'b1},
    {CHAR_STAR,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_MINUS,         TYPED, KIND_FRAMING,   1'b0},
    {CHAR_NINE,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_CR,            TYPED, KIND_FRAMING,   1'b0},
    {8'h00,              TYPED, KIND_EMPTY_CMD, 1'b1},
    {CHAR_STAR,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_ZERO + 8'd2,   TYPED, KIND_FRAMING,   1'b0},
    {CHAR_CR,            TYPED, KIND_FRAMING,   1'b0},
    {8'hFF,              TYPED, KIND_FRAMING,   1'b0},
    {CHAR_DOLLAR,        TYPED, KIND_FRAMING,   1'b0},
    {CHAR_ZERO,          TYPED, KIND_FRAMING,   1'b0},
    {CHAR_CR,            TYPED, KIND_FRAMING,   1'b0},
    {8'h0A,              FREE,  KIND_FRAMING,   1'b0},
    {CHAR_CR,            FREE,  KIND_FRAMING,   1'b0},
    {8'h0A,              FREE,  KIND_FRAMING,   1'b0},
    {CHAR_DOLLAR,        FREE,  KIND_FRAMING,   1'b0},
    {CHAR_ZERO + 8'd2,   FREE,  KIND_FRAMING,   1'b0},
    {CHAR_CR,            FREE,  KIND_FRAMING,   1'b0},
    {8'h5A,              FREE,  KIND_FRAMING,   1'b0},
    {8'h00,              FREE,  KIND_FRAMING,   1'b0},
    {8'hFF,              FREE,  KIND_FRAMING,   1'b0},
    {CHAR_CR,            FREE,  KIND_FRAMING,   1'b0},
    {8'hFF,              FREE,  KIND_FRAMING,   1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic        argument_last;
  logic        command_last;
  logic [19:0] argument_number;
  logic [2:0]  error_code;

  resp_multibulk_request_deframer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .argument_last   (argument_last),
    .command_last    (command_last),
    .argument_number (argument_number),
    .error_code      (error_code)
  );

  always #1 clk = ~clk;

  // Predictor state, starting at its reset values.
  parse_phase_e ph         = PH_START;
  int unsigned  args_left  = 0;
  int unsigned  bytes_left = 0;
  int unsigned  num_value  = 0;
  num_flags_t   flags      = '0;
  int unsigned  line_len   = 0;
  logic [19:0]  arg_index  = '0;
  logic         closed     = 1'b0;
  // Predictor copy of the limit registers.
  int unsigned  lim_line   = 32'(MAX_LINE_RESET);
  int unsigned  lim_count  = 32'(MAX_COUNT_RESET);
  int unsigned  lim_length = 32'(MAX_LENGTH_RESET);

  stim_t       request_bytes[$];    // bytes still to be sent
  result_t     pending_results[$];  // results of accepted bytes, oldest first
  stim_t       on_wire;             // the byte now offered on the input
  logic        steady;              // no idling on either side while set
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fails        = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_run    = 0;

  // Works out the result word that one request byte gives, and advances the parser.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t         r;
    longint unsigned grown;
    r = '0;
    if (!closed) begin
      case (ph)
        PH_COUNT, PH_LENGTH: begin
          if (b == CHAR_CR) begin
            ph = (ph == PH_COUNT) ? PH_COUNT_SKIP : PH_LENGTH_SKIP;
          end else if (line_len >= lim_line) begin
            r.kind = KIND_ERROR;
            r.err  = (ph == PH_COUNT) ? ERR_COUNT_LONG : ERR_LENGTH_LONG;
          end else begin
            // Decimal syntax: optional leading minus, then "0" alone or a nonzero digit
            // followed by digits. Once malformed, later bytes change nothing.
            if (!flags.bad) begin
              if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                if (flags.zero) begin
                  flags.bad = 1'b1;
                end else if (!flags.digits) begin
                  if (b == CHAR_ZERO) begin
                    if (flags.sign) begin
                      flags.bad = 1'b1;
                    end else begin
                      flags.zero   = 1'b1;
                      flags.digits = 1'b1;
                    end
                  end else begin
                    flags.digits = 1'b1;
                    num_value    = 32'(b - CHAR_ZERO);
                  end
                end else if (!flags.over) begin
                  grown = 64'(num_value) * 64'd10 + 64'(b - CHAR_ZERO);
                  if (grown > 64'(NUMBER_MAX)) flags.over = 1'b1;
                  else num_value = 32'(grown);
                end
              end else if (b == CHAR_MINUS && line_len == 0) begin
                flags.sign = 1'b1;
              end else begin
                flags.bad = 1'b1;
              end
            end
            line_len++;
          end
        end
        PH_COUNT_SKIP: begin
          // The decision on the count falls on the byte after CR, whatever it holds.
          if (!flags.digits || flags.bad) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_BAD_COUNT;
          end else if (flags.sign || num_value == 0) begin
            r.kind  = KIND_EMPTY_CMD;
            r.clast = 1'b1;
            ph      = PH_START;
          end else if (flags.over || num_value > lim_count ||
                       64'(num_value) > COUNT_FIELD_MAX) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_BAD_COUNT;
          end else begin
            args_left = num_value;
            arg_index = '0;
            ph        = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (b == CHAR_DOLLAR) begin
            num_value = 0;
            flags     = '0;
            line_len  = 0;
            ph        = PH_LENGTH;
          end else begin
            r.kind = KIND_ERROR;
            r.err  = ERR_NO_DOLLAR;
          end
        end
        PH_LENGTH_SKIP: begin
          if (!flags.digits || flags.bad || flags.sign || flags.over ||
              num_value > lim_length || 64'(num_value) > LENGTH_FIELD_MAX) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_BAD_LENGTH;
          end else if (num_value == 0) begin
            r.kind  = KIND_EMPTY_ARG;
            r.alast = 1'b1;
            r.clast = (args_left <= 1);
            r.anum  = arg_index;
            ph      = PH_TRAIL1;
          end else begin
            bytes_left = num_value;
            ph         = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.kind    = KIND_PAYLOAD;
          r.payload = b;
          r.anum    = arg_index;
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) begin
            r.alast = 1'b1;
            r.clast = (args_left <= 1);
            ph      = PH_TRAIL1;
          end
        end
        PH_TRAIL1: begin
          ph = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          if (args_left > 0) args_left--;
          if (args_left == 0) begin
            arg_index = '0;
            ph        = PH_START;
          end else begin
            arg_index = arg_index + 20'd1;
            ph        = PH_DOLLAR;
          end
        end
        default: begin
          if (b == CHAR_STAR) begin
            num_value = 0;
            flags     = '0;
            line_len  = 0;
            ph        = PH_COUNT;
          end else begin
            r.kind = KIND_ERROR;
            r.err  = ERR_INLINE;
          end
        end
      endcase
      // Any fault closes the parser for the rest of the run.
      if (r.kind == KIND_ERROR) begin
        closed = 1'b1;
        ph     = PH_START;
      end
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stim_t s;
    s.data  = b;
    s.typed = 1'b0;
    s.want  = '0;
    request_bytes.push_back(s);
  endtask

  task automatic push_decimal(input int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CHAR_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) push_byte(digits[i]);
  endtask

  // Appends one well-formed request that fits the current limits. Count and length lines
  // are kept short enough for the line limit, so no request here can fault.
  task automatic add_command();
    int unsigned pick, n, nd, len, len_cap;
    pick = $urandom_range(0, 9);
    push_byte(CHAR_STAR);
    if (pick == 0 || (pick == 1 && lim_line < 2)) begin
      // Zero count: an empty command.
      push_byte(CHAR_ZERO);
      push_byte(CHAR_CR);
      push_byte(rand_byte());
    end else if (pick == 1) begin
      // Negative count, at times far beyond 31 bits: still an empty command.
      nd = $urandom_range(1, (lim_line - 1 < 12) ? lim_line - 1 : 12);
      push_byte(CHAR_MINUS);
      push_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
      repeat (nd - 1) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      push_byte(CHAR_CR);
      push_byte(rand_byte());
    end else begin
      n = $urandom_range(1, (lim_count < 4) ? lim_count : 4);
      push_decimal(n);
      push_byte(CHAR_CR);
      push_byte(rand_byte());
      repeat (n) begin
        // Most arguments are short; one in eight is longer.
        len_cap = ($urandom_range(0, 7) == 0) ? 40 : 6;
        if (lim_line == 1 && len_cap > 9) len_cap = 9;
        if (lim_length < len_cap) len_cap = lim_length;
        len = $urandom_range(0, len_cap);
        push_byte(CHAR_DOLLAR);
        push_decimal(len);
        push_byte(CHAR_CR);
        push_byte(rand_byte());
        repeat (len) push_byte(rand_byte());
        push_byte(rand_byte());
        push_byte(rand_byte());
      end
    end
  endtask

  // Appends one broken request of a randomly chosen fault, then noise for the closed
  // parser. Limits are small when this is called, so each line not meant to overrun fits.
  task automatic add_fault();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: begin
        // A first byte other than the star: inline request.
        b = rand_byte();
        if (b == CHAR_STAR) b = CHAR_DOLLAR;
        push_byte(b);
      end
      1: begin
        // One character more than the line limit allows after the star.
        push_byte(CHAR_STAR);
        repeat (lim_line + 1) push_byte(CHAR_ZERO + 8'd1);
      end
      2: begin
        push_byte(CHAR_STAR);
        case ($urandom_range(0, 4))
          0: ;
          1: begin
            push_byte(CHAR_MINUS);
            push_byte(CHAR_ZERO);
          end
          2: begin
            push_byte(CHAR_ZERO);
            push_byte(CHAR_ZERO);
          end
          3: push_decimal(lim_count + 1);
          default: push_byte(8'h2B);
        endcase
        push_byte(CHAR_CR);
        push_byte(rand_byte());
      end
      3: begin
        push_byte(CHAR_STAR);
        push_byte(CHAR_ZERO + 8'd1);
        push_byte(CHAR_CR);
        push_byte(rand_byte());
        b = rand_byte();
        if (b == CHAR_DOLLAR) b = CHAR_STAR;
        push_byte(b);
      end
      4: begin
        push_byte(CHAR_STAR);
        push_byte(CHAR_ZERO + 8'd1);
        push_byte(CHAR_CR);
        push_byte(rand_byte());
        push_byte(CHAR_DOLLAR);
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            push_byte(CHAR_MINUS);
            push_byte(CHAR_ZERO + 8'd1);
          end
          2: push_decimal(lim_length + 1);
          default: begin
            push_byte(CHAR_ZERO + 8'd1);
            push_byte(8'h78);
          end
        endcase
        push_byte(CHAR_CR);
        push_byte(rand_byte());
      end
      default: begin
        push_byte(CHAR_STAR);
        push_byte(CHAR_ZERO + 8'd1);
        push_byte(CHAR_CR);
        push_byte(rand_byte());
        push_byte(CHAR_DOLLAR);
        repeat (lim_line + 1) push_byte(CHAR_ZERO + 8'd7);
      end
    endcase
    repeat ($urandom_range(20, 40)) push_byte(rand_byte());
  endtask

  // Offers one word after an optional gap and holds it until it is taken.
  task automatic send_word(input stim_t s);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= s.data;
    on_wire   <= s;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_all();
    while (request_bytes.size() != 0) send_word(request_bytes.pop_front());
    in_valid <= 1'b0;
  endtask

  // Each byte gives exactly one result, so the block is idle once the counts agree.
  task automatic wait_drained();
    while (results_seen != words_sent) @(posedge clk);
  endtask

  // Writes all three limits one after another, with the input side quiet.
  task automatic load_limits(input int unsigned line, input int unsigned count,
                             input int unsigned length);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_LINE;
    cfg_data  <= 30'(line);
    @(posedge clk);
    cfg_index <= REG_MAX_COUNT;
    cfg_data  <= 30'(count);
    @(posedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= 30'(length);
    @(posedge clk);
    cfg_write  <= 1'b0;
    lim_line   = line & 32'h1FFFF;
    lim_count  = count & 32'h1FFFFF;
    lim_length = length & 32'h3FFFFFFF;
  endtask

  // Result side: stall runs of random length; no new run starts while the steady flag is set.
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!steady) stall_run = pick_gap();
    end
  end

  // Checker and predictor feed. All handshake signals are read at the edge, before any
  // update of that edge lands, so both sides see the same accepted words.
  always @(posedge clk) begin
    result_t want, got;
    logic    took_in, took_out;
    took_in  = !rst && in_valid && !in_stall;
    took_out = !rst && out_valid && !out_stall;
    if (took_out) begin
      results_seen++;
      got = {kind, payload_byte, argument_last, command_last, argument_number, error_code};
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload, got.payload);
        check_field("argument_last", want.alast, got.alast);
        check_field("command_last", want.clast, got.clast);
        check_field("argument_number", want.anum, got.anum);
        check_field("error_code", want.err, got.err);
      end
    end
    if (took_in) begin
      // The predictor steps on every byte; a typed-in row overrides its answer.
      want = deframe_byte(data_byte);
      pending_results.push_back(on_wire.typed ? on_wire.want : want);
    end
    if (took_in || took_out) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_t       s;
    int unsigned line, count, length;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    cfg_write = 1'b0;
    cfg_index = REG_MAX_LINE;
    cfg_data  = '0;
    on_wire   = '0;
    steady    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset limits.
    foreach (DIRECTED_ROWS[i]) begin
      s.data       = DIRECTED_ROWS[i].data;
      s.typed      = DIRECTED_ROWS[i].typed;
      s.want       = '0;
      s.want.kind  = DIRECTED_ROWS[i].kind;
      s.want.clast = DIRECTED_ROWS[i].clast;
      request_bytes.push_back(s);
    end
    send_all();

    // Random part, one phase per limit setting. The sender waits for every result
    // before each limit change. A fault can only be sent once, since it closes the
    // parser until reset, so it ends the last phase, which runs under small limits.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      case (p)
        0: begin
          line   = 32'(MAX_LINE_RESET);
          count  = 32'(MAX_COUNT_RESET);
          length = 32'(MAX_LENGTH_RESET);
        end
        1: begin
          line   = 1;
          count  = 1;
          length = 0;
        end
        2, 4: begin
          line   = $urandom_range(1, 65536);
          count  = $urandom_range(1, 1048576);
          length = $urandom_range(0, 536870912);
        end
        3: begin
          line   = 2;
          count  = 3;
          length = 5;
        end
        default: begin
          line   = $urandom_range(4, 8);
          count  = $urandom_range(1, 99);
          length = $urandom_range(0, 99);
        end
      endcase
      load_limits(line, count, length);
      steady = (p == 3);
      while (request_bytes.size() < PHASE_BYTES) add_command();
      if (p == PHASE_COUNT - 1) add_fault();
      send_all();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/rmbd_pkg.sv
hw/rtl/rmbd_number.sv
hw/rtl/resp_multibulk_request_deframer.sv
hw/rtl/rmbd_checker.sv
verif/tb_resp_multibulk_request_deframer.sv
